### rtl/pidvdt_pkg.sv
// pidvdt_pkg: shared widths, constants and payload types for the variable-interval pid block
// used by pid_controller_variable_dt, pid_step_checker and tb_top; no dependencies

package pidvdt_pkg;

	localparam int DATA_W    = 32;
	localparam int TS_W      = 48;
	localparam int LIMIT_W   = 47;
	localparam int ERR_W     = DATA_W + 1;
	localparam int DIFF_W    = ERR_W + 1;
	localparam int ACC_W     = 48;
	localparam int CFG_IDX_W = 3;
	localparam int FRAC_W    = 16;

	// digit-serial multiplier: 4-bit digits of a 36-bit multiplier against a 48-bit multiplicand
	localparam int DIGIT_W    = 4;
	localparam int MPL_W      = 36;
	localparam int MCAND_W    = 48;
	localparam int PART_W     = MCAND_W + DIGIT_W;
	localparam int PROD_W     = MPL_W + MCAND_W;
	localparam int MUL_DIGITS = MPL_W / DIGIT_W;
	localparam int MUL_DONE   = MUL_DIGITS + 1;

	// bit-serial restoring divider
	localparam int QUO_W     = 49;
	localparam int DIV_STEPS = QUO_W;
	localparam int CNT_W     = 6;

	localparam int PVAL_W = 49;
	localparam int IMAG_W = 61;
	localparam int SUM_W  = 62;
	localparam int ACCX_W = 50;

	localparam logic [QUO_W-1:0]  INC_SAT  = QUO_W'(1) << 48;
	localparam logic [IMAG_W-1:0] TERM_SAT = IMAG_W'(1) << 60;

	localparam logic CMD_STEP  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_LOW     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_HIGH    = 3'd5;

	localparam logic [DATA_W-1:0]  RST_PROP_GAIN   = 32'h0000_8000;
	localparam logic [DATA_W-1:0]  RST_INTEG_GAIN  = 32'h0000_0000;
	localparam logic [DATA_W-1:0]  RST_DERIV_GAIN  = 32'h0000_199A;
	localparam logic [LIMIT_W-1:0] RST_INTEG_LIMIT = 47'h0000_0001_0000;
	localparam logic [DATA_W-1:0]  RST_OUT_LOW     = 32'hFFFF_0000;
	localparam logic [DATA_W-1:0]  RST_OUT_HIGH    = 32'h0001_0000;

	typedef enum logic [1:0] {
		KIND_FULL  = 2'd0,
		KIND_FIRST = 2'd1,
		KIND_STALE = 2'd2
	} kind_t;

	typedef struct packed {
		logic                     command;
		logic signed [DATA_W-1:0] target;
		logic signed [DATA_W-1:0] measured;
		logic [TS_W-1:0]          timestamp;
	} step_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] drive;
		kind_t                    kind;
	} result_t;

endpackage

### rtl/pid_controller_variable_dt.sv
// pid_controller_variable_dt: fixed-point pid with integral clamp and variable sample interval
// depends on pidvdt_pkg
//
// usage:
//   step channel (step_valid/step_ready/step) takes one request at a time: a control step or
//   a clear. a clear resets integral, last error, last time and the sample flag, no result.
//   result channel (result_valid/result_ready/result) returns one item per control step.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready; write while idle.
// sequence:
//   full pid step: four products on one shared 48x4 digit multiplier (proportional, integral
//   increment, integral, derivative), then a 1-bit-per-cycle restoring divide of the
//   derivative product by the sample interval.
//   first-sample and non-advancing steps: proportional product only.
//   clear: taken in the idle state, no computation.
// reset clears state, loads the default gains and bounds and leaves the result channel empty.
// a stalled receiver holds the result register; the next request is taken meanwhile and its
// result waits in the final state until the register frees up.

module pid_controller_variable_dt (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  step_valid,
	output logic                                  step_ready,
	input  pidvdt_pkg::step_t                     step,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output pidvdt_pkg::result_t                   result,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [pidvdt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pidvdt_pkg::LIMIT_W-1:0]        cfg_data
);
	import pidvdt_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_MP   = 7'b0000010,
		S_MINC = 7'b0000100,
		S_MI   = 7'b0001000,
		S_MD   = 7'b0010000,
		S_DIV  = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] cnt_q;
	kind_t kind_q;
	logic result_valid_q;
	result_t result_q;

	logic [DATA_W-1:0]  prop_gain_q, integ_gain_q, deriv_gain_q, out_low_q, out_high_q;
	logic [LIMIT_W-1:0] integ_limit_q;

	logic [ACC_W-1:0] integ_acc_q;
	logic [ERR_W-1:0] prev_error_q;
	logic [TS_W-1:0]  prev_time_q;
	logic             have_prev_q;

	logic [ERR_W-1:0]  err_q;
	logic [DIFF_W-1:0] diff_q;
	logic [TS_W-1:0]   dt_q;

	logic [PROD_W-1:0]  prod_q;
	logic [MPL_W-1:0]   mpl_q;
	logic [MCAND_W-1:0] mc_q;
	logic               mul_neg_q;
	logic [QUO_W-1:0]   quo_q;
	logic [TS_W-1:0]    rem_q;
	logic [SUM_W-1:0]   sum_q;

	logic [ERR_W-1:0]  err_w;
	logic [DIFF_W-1:0] diff_w;
	logic [TS_W:0]     dt_w;
	logic              advance_w;
	logic              accept_w, mul_busy, mul_fin, out_load;

	logic [DATA_W-1:0]  prop_mag, ig_mag, dg_mag;
	logic [ERR_W-1:0]   err_mag;
	logic [DIFF_W-1:0]  diff_mag;
	logic [LIMIT_W-1:0] acc_mag;
	logic [MPL_W-1:0]   ld_mpl;
	logic [MCAND_W-1:0] ld_mc;
	logic               ld_neg;

	logic [PART_W-1:0]  partial, step_sum;
	logic               round_w;
	logic [PROD_W-FRAC_W-1:0] mag_sh;
	logic [PVAL_W-1:0]  p_val;
	logic [QUO_W-1:0]   inc_mag;
	logic [ACCX_W-1:0]  inc_s, acc_w, lim_w, nlim_w, acc_c;
	logic [IMAG_W-1:0]  i_mag;
	logic [SUM_W-1:0]   i_val, dq_val;
	logic [TS_W:0]      shifted, dsub;
	logic               ge_w;
	logic [SUM_W-1:0]   hi_ext, lo_ext, hi_clip;
	logic [DATA_W-1:0]  drive_w;

	assign step_ready   = (state_q == S_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign accept_w = step_valid && step_ready;
	assign mul_busy = (state_q == S_MP) || (state_q == S_MINC) || (state_q == S_MI) ||
		(state_q == S_MD);
	assign mul_fin  = mul_busy && (cnt_q == CNT_W'(MUL_DONE));
	assign out_load = (state_q == S_OUT) && (!result_valid_q || result_ready);

	// request decode
	assign err_w = {step.target[DATA_W-1], step.target} -
		{step.measured[DATA_W-1], step.measured};
	assign diff_w = {err_w[ERR_W-1], err_w} - {prev_error_q[ERR_W-1], prev_error_q};
	assign dt_w = {1'b0, step.timestamp} - {1'b0, prev_time_q};
	assign advance_w = !dt_w[TS_W] && (dt_w[TS_W-1:0] != '0);

	// operand magnitudes
	assign prop_mag = prop_gain_q[DATA_W-1] ? (~prop_gain_q + 1'b1) : prop_gain_q;
	assign ig_mag   = integ_gain_q[DATA_W-1] ? (~integ_gain_q + 1'b1) : integ_gain_q;
	assign dg_mag   = deriv_gain_q[DATA_W-1] ? (~deriv_gain_q + 1'b1) : deriv_gain_q;
	assign err_mag  = err_q[ERR_W-1] ? (~err_q + 1'b1) : err_q;
	assign diff_mag = diff_q[DIFF_W-1] ? (~diff_q + 1'b1) : diff_q;
	assign acc_mag  = integ_acc_q[ACC_W-1] ? LIMIT_W'(~integ_acc_q + 1'b1) :
		integ_acc_q[LIMIT_W-1:0];

	always_comb begin
		ld_mpl = '0;
		ld_mc  = '0;
		ld_neg = 1'b0;
		unique case (state_q)
			S_MP: begin
				ld_mpl = MPL_W'(prop_mag);
				ld_mc  = MCAND_W'(err_mag);
				ld_neg = prop_gain_q[DATA_W-1] ^ err_q[ERR_W-1];
			end
			S_MINC: begin
				ld_mpl = MPL_W'(err_mag);
				ld_mc  = dt_q;
				ld_neg = err_q[ERR_W-1];
			end
			S_MI: begin
				ld_mpl = MPL_W'(ig_mag);
				ld_mc  = MCAND_W'(acc_mag);
				ld_neg = integ_gain_q[DATA_W-1] ^ integ_acc_q[ACC_W-1];
			end
			S_MD: begin
				ld_mpl = MPL_W'(dg_mag);
				ld_mc  = MCAND_W'(diff_mag);
				ld_neg = deriv_gain_q[DATA_W-1] ^ diff_q[DIFF_W-1];
			end
			default: begin
				ld_neg = 1'b0;
			end
		endcase
	end

	// one digit step of the multiplier
	assign partial  = mc_q * mpl_q[DIGIT_W-1:0];
	assign step_sum = PART_W'(prod_q[PROD_W-1:MPL_W]) + partial;

	// product post-processing: floor scaling, saturation, sign
	assign round_w = mul_neg_q && (prod_q[FRAC_W-1:0] != '0);
	assign mag_sh  = prod_q[PROD_W-1:FRAC_W] + (PROD_W-FRAC_W)'(round_w);
	assign p_val   = mul_neg_q ? (~mag_sh[PVAL_W-1:0] + 1'b1) : mag_sh[PVAL_W-1:0];

	assign inc_mag = (prod_q >= PROD_W'(INC_SAT)) ? INC_SAT : prod_q[QUO_W-1:0];
	assign inc_s   = mul_neg_q ? (~ACCX_W'(inc_mag) + 1'b1) : ACCX_W'(inc_mag);
	assign acc_w   = {{(ACCX_W-ACC_W){integ_acc_q[ACC_W-1]}}, integ_acc_q} + inc_s;
	assign lim_w   = ACCX_W'(integ_limit_q);
	assign nlim_w  = ~lim_w + 1'b1;

	always_comb begin
		priority if ($signed(acc_w) > $signed(lim_w)) begin
			acc_c = lim_w;
		end else if ($signed(acc_w) < $signed(nlim_w)) begin
			acc_c = nlim_w;
		end else begin
			acc_c = acc_w;
		end
	end

	assign i_mag  = (mag_sh > (PROD_W-FRAC_W)'(TERM_SAT)) ? TERM_SAT : mag_sh[IMAG_W-1:0];
	assign i_val  = mul_neg_q ? (~SUM_W'(i_mag) + 1'b1) : SUM_W'(i_mag);
	assign dq_val = mul_neg_q ? (~SUM_W'(quo_q) + 1'b1) : SUM_W'(quo_q);

	// one bit step of the divider
	assign shifted = {rem_q, quo_q[QUO_W-1]};
	assign ge_w    = shifted >= {1'b0, dt_q};
	assign dsub    = shifted - {1'b0, dt_q};

	// output clamp, upper bound first
	assign hi_ext  = {{(SUM_W-DATA_W){out_high_q[DATA_W-1]}}, out_high_q};
	assign lo_ext  = {{(SUM_W-DATA_W){out_low_q[DATA_W-1]}}, out_low_q};
	assign hi_clip = ($signed(sum_q) > $signed(hi_ext)) ? hi_ext : sum_q;
	assign drive_w = ($signed(hi_clip) < $signed(lo_ext)) ? out_low_q : hi_clip[DATA_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cnt_q          <= '0;
			kind_q         <= KIND_FULL;
			result_valid_q <= 1'b0;
			prop_gain_q    <= RST_PROP_GAIN;
			integ_gain_q   <= RST_INTEG_GAIN;
			deriv_gain_q   <= RST_DERIV_GAIN;
			integ_limit_q  <= RST_INTEG_LIMIT;
			out_low_q      <= RST_OUT_LOW;
			out_high_q     <= RST_OUT_HIGH;
			integ_acc_q    <= '0;
			prev_error_q   <= '0;
			prev_time_q    <= '0;
			have_prev_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_PROP_GAIN:   prop_gain_q   <= cfg_data[DATA_W-1:0];
					CFG_INTEG_GAIN:  integ_gain_q  <= cfg_data[DATA_W-1:0];
					CFG_DERIV_GAIN:  deriv_gain_q  <= cfg_data[DATA_W-1:0];
					CFG_INTEG_LIMIT: integ_limit_q <= cfg_data;
					CFG_OUT_LOW:     out_low_q     <= cfg_data[DATA_W-1:0];
					CFG_OUT_HIGH:    out_high_q    <= cfg_data[DATA_W-1:0];
					default: begin
					end
				endcase
			end

			if (result_valid_q && result_ready && !out_load) begin
				result_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (step_valid) begin
						if (step.command == CMD_CLEAR) begin
							integ_acc_q  <= '0;
							prev_error_q <= '0;
							prev_time_q  <= '0;
							have_prev_q  <= 1'b0;
						end else begin
							priority if (!have_prev_q) begin
								kind_q <= KIND_FIRST;
							end else if (!advance_w) begin
								kind_q <= KIND_STALE;
							end else begin
								kind_q <= KIND_FULL;
							end
							if (!have_prev_q || advance_w) begin
								prev_error_q <= err_w;
								prev_time_q  <= step.timestamp;
								have_prev_q  <= 1'b1;
							end
							cnt_q   <= '0;
							state_q <= S_MP;
						end
					end
				end
				S_MP, S_MINC, S_MI, S_MD: begin
					if (mul_fin) begin
						cnt_q <= '0;
						unique case (state_q)
							S_MP:    state_q <= (kind_q == KIND_FULL) ? S_MINC : S_OUT;
							S_MINC: begin
								integ_acc_q <= acc_c[ACC_W-1:0];
								state_q     <= S_MI;
							end
							S_MI:    state_q <= S_MD;
							default: state_q <= S_DIV;
						endcase
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DIV: begin
					if (cnt_q == CNT_W'(DIV_STEPS)) begin
						cnt_q   <= '0;
						state_q <= S_OUT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_OUT: begin
					if (out_load) begin
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept_w && step.command == CMD_STEP) begin
			err_q  <= err_w;
			diff_q <= diff_w;
			dt_q   <= dt_w[TS_W-1:0];
		end

		if (mul_busy) begin
			if (cnt_q == '0) begin
				prod_q    <= '0;
				mpl_q     <= ld_mpl;
				mc_q      <= ld_mc;
				mul_neg_q <= ld_neg;
			end else if (cnt_q <= CNT_W'(MUL_DIGITS)) begin
				prod_q <= {step_sum, prod_q[MPL_W-1:DIGIT_W]};
				mpl_q  <= mpl_q >> DIGIT_W;
			end
		end

		if (mul_fin) begin
			unique case (state_q)
				S_MP:   sum_q <= {{(SUM_W-PVAL_W){p_val[PVAL_W-1]}}, p_val};
				S_MI:   sum_q <= sum_q + i_val;
				S_MD: begin
					quo_q <= mag_sh[QUO_W-1:0];
					rem_q <= '0;
				end
				default: begin
				end
			endcase
		end

		if (state_q == S_DIV) begin
			if (cnt_q == CNT_W'(DIV_STEPS)) begin
				sum_q <= sum_q + dq_val;
			end else begin
				rem_q <= ge_w ? dsub[TS_W-1:0] : shifted[TS_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], ge_w};
			end
		end

		if (out_load) begin
			result_q.drive <= drive_w;
			result_q.kind  <= kind_q;
		end
	end

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside the output state");

	a_mul_count: assert property (@(posedge clk) disable iff (!arst_n)
		mul_busy |-> cnt_q <= CNT_W'(MUL_DONE))
		else $error("multiplier digit count overrun");

	a_clear_state: assert property (@(posedge clk) disable iff (!arst_n)
		accept_w && step.command == CMD_CLEAR |=> !have_prev_q && integ_acc_q == '0)
		else $error("clear request left controller state");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT && result_valid_q && !result_ready |=> state_q == S_OUT)
		else $error("pending result overwritten under stall");

endmodule

### tb/sv/pid_step_checker.sv
`timescale 1ns / 1ps
// pid_step_checker: watches the step, result and register channels of the pid block,
// predicts each control step in fixed point and compares results in arrival order
// depends on pidvdt_pkg

module pid_step_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             step_valid,
	input  logic                             step_ready,
	input  pidvdt_pkg::step_t                step,
	input  logic                             result_valid,
	input  logic                             result_ready,
	input  pidvdt_pkg::result_t              result,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [pidvdt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pidvdt_pkg::LIMIT_W-1:0]   cfg_data,
	output int                               errors,
	output int                               pending,
	output int                               checked
);
	import pidvdt_pkg::*;

	localparam int MAX_REPORTS = 20;

	logic signed [DATA_W-1:0] kp, ki, kd, lo_bound, hi_bound;
	logic [LIMIT_W-1:0]       i_limit;
	logic signed [ACC_W-1:0]  integral;
	logic signed [ERR_W-1:0]  last_err;
	logic [TS_W-1:0]          last_ts;
	logic                     primed;
	result_t                  drive_due[$];
	int                       fail_count;
	int                       compared;

	// floor(g * v / 2^16) with magnitude limited to the term ceiling
	function automatic longint gain_product(longint g, longint v);
		logic [63:0]  gm, vm;
		logic [127:0] full, mag;
		bit           neg;
		neg = (g < 0) != (v < 0);
		gm = g < 0 ? -g : g;
		vm = v < 0 ? -v : v;
		full = {64'd0, gm} * {64'd0, vm};
		mag = full >> FRAC_W;
		if (neg && full[FRAC_W-1:0] != '0)
			mag = mag + 1;
		if (mag > 128'(TERM_SAT))
			mag = 128'(TERM_SAT);
		return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
	endfunction

	task automatic predict_step(input step_t s);
		longint       err, p, i, d, sum, dt, acc, inc, lim;
		logic [63:0]  em;
		logic [127:0] spread;
		result_t      r;
		if (s.command == CMD_CLEAR) begin
			integral = '0;
			last_err = '0;
			last_ts = '0;
			primed = 1'b0;
		end else begin
			err = $signed(s.target);
			err = err - $signed(s.measured);
			p = gain_product(kp, err);
			if (!primed) begin
				last_err = err[ERR_W-1:0];
				last_ts = s.timestamp;
				primed = 1'b1;
				sum = p;
				r.kind = KIND_FIRST;
			end else if (s.timestamp <= last_ts) begin
				sum = p;
				r.kind = KIND_STALE;
			end else begin
				dt = longint'(s.timestamp - last_ts);
				em = err < 0 ? -err : err;
				spread = {64'd0, em} * {64'd0, 64'(dt)};
				if (spread > 128'(INC_SAT))
					spread = 128'(INC_SAT);
				inc = longint'(spread[63:0]);
				if (err < 0)
					inc = -inc;
				acc = integral + inc;
				lim = longint'(i_limit);
				if (acc > lim)
					acc = lim;
				if (acc < -lim)
					acc = -lim;
				integral = acc[ACC_W-1:0];
				i = gain_product(ki, acc);
				d = gain_product(kd, err - last_err);
				d = d < 0 ? -((-d) / dt) : d / dt;
				sum = p + i + d;
				last_err = err[ERR_W-1:0];
				last_ts = s.timestamp;
				r.kind = KIND_FULL;
			end
			// upper bound first so the lower bound wins when they cross
			if (sum > hi_bound)
				sum = hi_bound;
			if (sum < lo_bound)
				sum = lo_bound;
			r.drive = sum[DATA_W-1:0];
			drive_due.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			kp = RST_PROP_GAIN;
			ki = RST_INTEG_GAIN;
			kd = RST_DERIV_GAIN;
			i_limit = RST_INTEG_LIMIT;
			lo_bound = RST_OUT_LOW;
			hi_bound = RST_OUT_HIGH;
			integral = '0;
			last_err = '0;
			last_ts = '0;
			primed = 1'b0;
			drive_due.delete();
			fail_count = 0;
			compared = 0;
			errors <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (drive_due.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: unexpected result, expected none, actual drive %h kind %0d",
							$time, result.drive, result.kind);
				end else begin
					want = drive_due.pop_front();
					compared++;
					if (want.drive !== result.drive) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS)
							$display("%0t: drive mismatch, expected %h actual %h",
								$time, want.drive, result.drive);
					end
					if (want.kind !== result.kind) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS)
							$display("%0t: kind mismatch, expected %0d actual %0d",
								$time, want.kind, result.kind);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PROP_GAIN:   kp = cfg_data[DATA_W-1:0];
					CFG_INTEG_GAIN:  ki = cfg_data[DATA_W-1:0];
					CFG_DERIV_GAIN:  kd = cfg_data[DATA_W-1:0];
					CFG_INTEG_LIMIT: i_limit = cfg_data;
					CFG_OUT_LOW:     lo_bound = cfg_data[DATA_W-1:0];
					CFG_OUT_HIGH:    hi_bound = cfg_data[DATA_W-1:0];
					default: ;
				endcase
			end
			if (step_valid && step_ready)
				predict_step(step);
			errors <= fail_count;
			pending <= drive_due.size();
			checked <= compared;
		end
	end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for pid_controller_variable_dt; drives step, result and
// register channels with random idling, prediction and comparison sit in pid_step_checker
// depends on pidvdt_pkg, pid_controller_variable_dt and pid_step_checker

module tb_top;
	import pidvdt_pkg::*;

	localparam int DRAIN_CYCLES = 120;
	localparam int STALL_LIMIT  = 5000;
	localparam int HOLD_CYCLES  = 500;
	localparam int RAND_ITEMS   = 1930;
	localparam int PHASE_ITEMS  = 150;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	typedef enum int {
		SET_MODERATE,
		SET_MAX,
		SET_MIN,
		SET_CROSSED,
		SET_RANDOM
	} setting_t;

	logic                 clk;
	logic                 arst_n;
	logic                 step_valid;
	logic                 step_ready;
	step_t                step;
	logic                 result_valid;
	logic                 result_ready;
	result_t              result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [LIMIT_W-1:0]   cfg_data;
	int                   errors, pending, checked;

	int              n_steps = 0;
	int              n_clears = 0;
	int              n_settings = 0;
	int              hold_req = 0;
	int              holds_done = 0;
	int              stalled = 0;
	bit              step_burst = 1'b0;
	logic [TS_W-1:0] clock_ts;

	pid_controller_variable_dt u_top (.*);

	pid_step_checker u_check (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((step_valid && step_ready) || (result_valid && result_ready) ||
			(cfg_valid && cfg_ready))
			stalled <= 0;
		else
			stalled <= stalled + 1;
		if (stalled >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result side: random back-pressure, occasional long hold-off on request
	initial begin
		int w;
		int taken;
		bit take_burst;
		taken = 0;
		take_burst = 1'b0;
		result_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (taken % 40 == 0)
				take_burst = ($urandom_range(0, 3) == 0);
			w = take_burst ? 0 : $urandom_range(0, 8);
			if (hold_req > holds_done) begin
				w = HOLD_CYCLES;
				holds_done++;
			end
			if (w > 0) begin
				result_ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
			taken++;
		end
	end

	function automatic step_t make_step(logic cmd, logic [DATA_W-1:0] tgt,
		logic [DATA_W-1:0] meas, logic [TS_W-1:0] ts);
		step_t s;
		s.command = cmd;
		s.target = tgt;
		s.measured = meas;
		s.timestamp = ts;
		return s;
	endfunction

	function automatic logic [LIMIT_W-1:0] widen(logic [DATA_W-1:0] v);
		return {{(LIMIT_W - DATA_W){v[DATA_W-1]}}, v};
	endfunction

	function automatic logic [DATA_W-1:0] rand_value();
		if ($urandom_range(0, 4) == 0)
			return $urandom;
		return $urandom_range(0, 32'h80000) - 32'h40000;
	endfunction

	function automatic logic [TS_W-1:0] rand_dt();
		case ($urandom_range(0, 19))
			0:       return TS_W'($urandom) << $urandom_range(0, 16);
			1, 2, 3: return TS_W'($urandom_range(17, 5000));
			default: return TS_W'($urandom_range(1, 16));
		endcase
	endfunction

	// mostly advancing sample times, some stale, clears and jumps as noise
	function automatic step_t random_item();
		logic [TS_W-1:0]   ts;
		logic [DATA_W-1:0] tgt, meas;
		int                r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return make_step(CMD_CLEAR, $urandom, $urandom, TS_W'({$urandom, $urandom}));
		if (r < 10) begin
			ts = clock_ts - $urandom_range(0, 40);
		end else if (r < 13) begin
			ts = TS_W'({$urandom, $urandom});
			clock_ts = ts;
		end else begin
			ts = clock_ts + rand_dt();
			clock_ts = ts;
		end
		tgt = rand_value();
		if ($urandom_range(0, 3) == 0)
			meas = rand_value();
		else
			meas = tgt - ($urandom_range(0, 32'h20000) - 32'h10000);
		return make_step(CMD_STEP, tgt, meas, ts);
	endfunction

	task automatic send_request(input step_t s);
		int gap;
		step <= s;
		step_valid <= 1'b1;
		@(posedge clk);
		while (!step_ready) @(posedge clk);
		if (s.command == CMD_CLEAR)
			n_clears++;
		else
			n_steps++;
		gap = step_burst ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			step_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		step_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic apply_setting(input setting_t m);
		logic [DATA_W-1:0]  pg, ig, dg, ol, oh;
		logic [LIMIT_W-1:0] lim;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		pg = $urandom_range(0, 32'h40000) - 32'h20000;
		ig = $urandom_range(0, 2000) - 500;
		dg = $urandom_range(0, 32'h40000) - 32'h10000;
		lim = LIMIT_W'($urandom_range(0, 32'h0100_0000));
		ol = -$urandom_range(32'h8000, 32'h80000);
		oh = $urandom_range(32'h8000, 32'h80000);
		case (m)
			SET_MAX: begin
				pg = 32'h7FFF_FFFF;
				ig = 32'h7FFF_FFFF;
				dg = 32'h7FFF_FFFF;
				lim = '1;
				ol = 32'h8000_0000;
				oh = 32'h7FFF_FFFF;
			end
			SET_MIN: begin
				pg = 32'h8000_0000;
				ig = 32'h8000_0000;
				dg = 32'h8000_0000;
				lim = '0;
				ol = 32'h8000_0000;
				oh = 32'h7FFF_FFFF;
			end
			SET_CROSSED: begin
				ol = $urandom_range(1, 32'h40000);
				oh = -$urandom_range(1, 32'h40000);
			end
			SET_RANDOM: begin
				pg = $urandom;
				ig = $urandom;
				dg = $urandom;
				lim = {15'($urandom), $urandom};
				ol = $urandom;
				oh = $urandom;
			end
			default: ;
		endcase
		cfg_valid <= 1'b1;
		write_reg(CFG_PROP_GAIN, widen(pg));
		write_reg(CFG_INTEG_GAIN, widen(ig));
		write_reg(CFG_DERIV_GAIN, widen(dg));
		write_reg(CFG_INTEG_LIMIT, lim);
		write_reg(CFG_OUT_LOW, widen(ol));
		write_reg(CFG_OUT_HIGH, widen(oh));
		// unmapped indexes must leave the settings alone
		if (m == SET_RANDOM || n_settings == 0) begin
			write_reg(CFG_SPARE_LO, {15'($urandom), $urandom});
			write_reg(CFG_SPARE_HI, {15'($urandom), $urandom});
		end
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	initial begin
		int sent;
		sent = 0;
		clock_ts = '0;
		arst_n <= 1'b0;
		step_valid <= 1'b0;
		step <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: first sample, stale and backward time, extreme errors and times
		send_request(make_step(CMD_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 48'd100));
		send_request(make_step(CMD_STEP, 32'h0001_0000, 32'h0, 48'd100));
		send_request(make_step(CMD_STEP, 32'h0, 32'h0001_0000, 48'd50));
		send_request(make_step(CMD_STEP, 32'h8000_0000, 32'h7FFF_FFFF, 48'd101));
		send_request(make_step(CMD_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 48'h8000_0000_0065));
		send_request(make_step(CMD_STEP, 32'h0000_8000, 32'h0000_8000, 48'hFFFF_FFFF_FFFF));
		send_request(make_step(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));
		send_request(make_step(CMD_STEP, 32'h0001_0000, 32'h0, 48'd0));
		send_request(make_step(CMD_STEP, 32'h0002_0000, 32'h0, 48'd0));
		send_request(make_step(CMD_STEP, 32'hFFFF_0000, 32'h0001_0000, 48'd7));

		// largest gains and limit: term and increment saturation
		apply_setting(SET_MAX);
		send_request(make_step(CMD_CLEAR, 32'h0, 32'h0, 48'd0));
		send_request(make_step(CMD_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 48'd5));
		send_request(make_step(CMD_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 48'd6));
		send_request(make_step(CMD_STEP, 32'h8000_0000, 32'h7FFF_FFFF, 48'h0100_0000_0006));
		send_request(make_step(CMD_STEP, 32'h8000_0000, 32'h7FFF_FFFF, 48'h0100_0000_0009));

		// most negative gains, zero integral limit
		apply_setting(SET_MIN);
		send_request(make_step(CMD_STEP, 32'h0003_0000, 32'hFFFF_8000, 48'h0100_0000_0014));
		send_request(make_step(CMD_STEP, 32'h0000_0001, 32'h0, 48'h0100_0000_0014));
		send_request(make_step(CMD_CLEAR, 32'h0, 32'h0, 48'd0));
		send_request(make_step(CMD_STEP, 32'h8000_0000, 32'h0, 48'd3));
		send_request(make_step(CMD_STEP, 32'h7FFF_FFFF, 32'h0, 48'd4));

		// crossed output bounds
		apply_setting(SET_CROSSED);
		send_request(make_step(CMD_STEP, 32'h0005_0000, 32'h0, 48'd10));
		send_request(make_step(CMD_STEP, 32'hFFFB_0000, 32'h0, 48'd11));
		send_request(make_step(CMD_STEP, 32'h0, 32'h0, 48'd12));

		for (int p = 0; sent < RAND_ITEMS; p++) begin
			apply_setting(setting_t'(p % 5));
			case ($urandom_range(0, 3))
				0:       clock_ts = TS_W'({$urandom, $urandom});
				1:       clock_ts = '1 - $urandom_range(0, 20000);
				default: clock_ts = TS_W'($urandom_range(0, 1000));
			endcase
			if ($urandom_range(0, 1) == 0) begin
				send_request(make_step(CMD_CLEAR, $urandom, $urandom, TS_W'({$urandom, $urandom})));
				sent++;
			end
			for (int k = 0; k < PHASE_ITEMS && sent < RAND_ITEMS; k++) begin
				if (k % 32 == 0)
					step_burst = ($urandom_range(0, 3) == 0);
				if (k == PHASE_ITEMS / 2 && (p == 2 || p == 8))
					hold_req++;
				send_request(random_item());
				sent++;
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("run covered %0d control steps and %0d clears over %0d register settings",
			n_steps, n_clears, n_settings);
		$display("%0d results compared in order, %0d long receiver hold-offs", checked, holds_done);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### sim.f
rtl/pidvdt_pkg.sv
rtl/pid_controller_variable_dt.sv
tb/sv/pid_step_checker.sv
tb/sv/tb_top.sv
